// ===== rtl/core/tqm_pkg.sv =====
package tqm_pkg;

	// Table size and field widths
	localparam int unsigned TIMERS      = 32;
	localparam int unsigned MAX_RESULTS = 32;
	localparam int unsigned TIME_W      = 64;
	localparam int unsigned TIMEOUT_W   = 32;
	localparam int unsigned GRAN_W      = 10;
	localparam int unsigned ID_W        = 5;
	localparam int unsigned IDX_W       = (TIMERS > 1) ? $clog2(TIMERS) : 1;
	localparam int unsigned CNT_W       = $clog2(TIMERS + 1);
	localparam int unsigned NRES_W      = $clog2(MAX_RESULTS + 1);

	// Remainder unit retires two dividend bits per cycle
	localparam int unsigned DIV_STEPS   = TIME_W / 2;
	localparam int unsigned DIVCNT_W    = $clog2(DIV_STEPS);

	localparam logic [GRAN_W-1:0] GRAN_RESET = GRAN_W'(100);

	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_START = 2'd1,
		FUNC_STOP  = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		KIND_EXPIRED   = 2'd0,
		KIND_STARTED   = 2'd1,
		KIND_STOPPED   = 2'd2,
		KIND_NOT_ARMED = 2'd3
	} kind_t;

	// Controller to datapath commands
	typedef struct packed {
		logic             load;      // capture the item fields
		logic             sum;       // now + timeout into sum and divider
		logic             div_step;  // two remainder steps
		logic             round;     // round sum up to the granularity
		logic             arm;       // store due time, arm, report start
		logic             rd_id;     // read due time of the addressed slot
		logic             stop;      // disarm, report stop
		logic             tick;      // advance now
		logic             scan_clr;  // clear best candidate and count
		logic             scan_rd;   // read the scan address
		logic [IDX_W-1:0] scan_addr;
		logic             expire;    // report and disarm best candidate
		logic             last;      // last flag for an expiry
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic best_v;    // a due armed timer was found
		logic one_cand;  // it was the only one
	} dp_sts_t;

endpackage

// ===== rtl/core/tqm_ram.sv =====
module tqm_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 32,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/tqm_ctrl.sv =====
module tqm_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [1:0]                func,
	input  logic [tqm_pkg::ID_W-1:0]  timer_id,
	input  tqm_pkg::dp_sts_t          sts,
	output tqm_pkg::dp_cmd_t          cmd,
	output logic                      busy
);

	import tqm_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIV,
		ST_ROUND,
		ST_ARM,
		ST_STOP_RD,
		ST_STOP_EMIT,
		ST_TICK,
		ST_SCAN,
		ST_SCAN_END,
		ST_PICK
	} state_t;

	state_t              state_q;
	logic [DIVCNT_W-1:0] divcnt_q;
	logic [IDX_W-1:0]    addr_q;
	logic [NRES_W-1:0]   nres_q;
	logic                id_ok;
	logic                last_exp;

	assign id_ok    = 32'(timer_id) < TIMERS;
	// Last expiry of a tick: no other candidate, or the result limit is hit
	assign last_exp = sts.one_cand || (nres_q == NRES_W'(MAX_RESULTS - 1));
	assign busy     = (state_q != ST_IDLE);

	// Command decode
	always_comb begin
		cmd           = '0;
		cmd.scan_addr = addr_q;
		case (state_q)
			ST_IDLE:      cmd.load = start;
			ST_SUM:       cmd.sum = 1'b1;
			ST_DIV:       cmd.div_step = 1'b1;
			ST_ROUND:     cmd.round = 1'b1;
			ST_ARM:       cmd.arm = 1'b1;
			ST_STOP_RD:   cmd.rd_id = 1'b1;
			ST_STOP_EMIT: cmd.stop = 1'b1;
			ST_TICK: begin
				cmd.tick     = 1'b1;
				cmd.scan_clr = 1'b1;
			end
			ST_SCAN:      cmd.scan_rd = 1'b1;
			ST_PICK: begin
				if (sts.best_v) begin
					cmd.expire   = 1'b1;
					cmd.last     = last_exp;
					cmd.scan_clr = !last_exp;
				end
			end
			default: ;
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			divcnt_q <= '0;
			addr_q   <= '0;
			nres_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						case (func_t'(func))
							FUNC_TICK:  state_q <= ST_TICK;
							FUNC_START: if (id_ok) state_q <= ST_SUM;
							FUNC_STOP:  if (id_ok) state_q <= ST_STOP_RD;
							default:    state_q <= ST_IDLE;
						endcase
					end
				end
				ST_SUM: begin
					divcnt_q <= '0;
					state_q  <= ST_DIV;
				end
				ST_DIV: begin
					divcnt_q <= divcnt_q + 1'b1;
					if (divcnt_q == DIVCNT_W'(DIV_STEPS - 1)) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND:     state_q <= ST_ARM;
				ST_ARM:       state_q <= ST_IDLE;
				ST_STOP_RD:   state_q <= ST_STOP_EMIT;
				ST_STOP_EMIT: state_q <= ST_IDLE;
				ST_TICK: begin
					addr_q  <= '0;
					nres_q  <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == IDX_W'(TIMERS - 1)) begin
						state_q <= ST_SCAN_END;
					end
				end
				ST_SCAN_END:  state_q <= ST_PICK;
				ST_PICK: begin
					if (!sts.best_v) begin
						state_q <= ST_IDLE;
					end else begin
						nres_q <= nres_q + 1'b1;
						if (last_exp) begin
							state_q <= ST_IDLE;
						end else begin
							addr_q  <= '0;
							state_q <= ST_SCAN;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/tqm_dp.sv =====
module tqm_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tqm_pkg::dp_cmd_t              cmd,
	output tqm_pkg::dp_sts_t              sts,
	input  logic [tqm_pkg::ID_W-1:0]      timer_id,
	input  logic [tqm_pkg::TIMEOUT_W-1:0] timeout,
	input  logic                          cfg_we,
	input  logic [tqm_pkg::GRAN_W-1:0]    cfg_wdata,
	output logic                          strobe,
	output logic [tqm_pkg::ID_W-1:0]      timer_id_res,
	output logic [1:0]                    kind,
	output logic [tqm_pkg::TIME_W-1:0]    due_time,
	output logic                          last
);

	import tqm_pkg::*;

	// One restoring remainder step: shift in a bit, subtract if it fits
	function automatic logic [GRAN_W-1:0] rem_step(input logic [GRAN_W-1:0] r,
			input logic b, input logic [GRAN_W-1:0] g);
		logic [GRAN_W:0] t;
		t = {r, b};
		if (t >= {1'b0, g}) begin
			t = t - {1'b0, g};
		end
		return t[GRAN_W-1:0];
	endfunction

	logic [GRAN_W-1:0]    gran_q;
	logic [TIME_W-1:0]    now_q;
	logic [TIMERS-1:0]    armed_q;
	logic [ID_W-1:0]      id_q;
	logic [TIMEOUT_W-1:0] timeout_q;
	logic [TIME_W-1:0]    sum_q;
	logic [TIME_W-1:0]    div_q;
	logic [GRAN_W-1:0]    rem_q;
	logic                 best_v_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [TIME_W-1:0]    best_due_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 vld_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic                 strobe_q;
	logic [ID_W-1:0]      res_id_q;
	kind_t                res_kind_q;
	logic [TIME_W-1:0]    res_due_q;
	logic                 res_last_q;

	logic [GRAN_W-1:0]    g_eff;
	logic [GRAN_W-1:0]    rem1;
	logic [GRAN_W-1:0]    rem2;
	logic [GRAN_W-1:0]    pad;
	logic [TIME_W-1:0]    sum_next;
	logic [IDX_W-1:0]     id_idx;
	logic [IDX_W-1:0]     raddr;
	logic [TIME_W-1:0]    rdata;
	logic                 hit;
	logic                 better;

	// Granularity of zero means no rounding
	assign g_eff    = (gran_q == '0) ? GRAN_W'(1) : gran_q;
	assign rem1     = rem_step(rem_q, div_q[TIME_W-1], g_eff);
	assign rem2     = rem_step(rem1, div_q[TIME_W-2], g_eff);
	assign pad      = (rem_q != '0) ? (g_eff - rem_q) : '0;
	assign sum_next = now_q + TIME_W'(timeout_q);
	assign id_idx   = IDX_W'(id_q);
	assign raddr    = cmd.scan_rd ? cmd.scan_addr : id_idx;

	// Due time store
	tqm_ram #(
		.WIDTH (TIME_W),
		.DEPTH (TIMERS)
	) u_due_ram (
		.clk   (clk),
		.we    (cmd.arm),
		.waddr (id_idx),
		.wdata (sum_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Scan compare on the registered read data
	assign hit    = vld_s1 && armed_q[idx_s1] && (rdata <= now_q);
	assign better = !best_v_q || (rdata < best_due_q);

	assign sts.best_v   = best_v_q;
	assign sts.one_cand = (cnt_q == CNT_W'(1));

	// Control state: config, time base, armed bits, scan status, strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gran_q   <= GRAN_RESET;
			now_q    <= '0;
			armed_q  <= '0;
			vld_s1   <= 1'b0;
			best_v_q <= 1'b0;
			cnt_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				gran_q <= cfg_wdata;
			end
			if (cmd.tick) begin
				now_q <= now_q + 1'b1;
			end
			if (cmd.arm) begin
				armed_q[id_idx] <= 1'b1;
			end
			if (cmd.stop) begin
				armed_q[id_idx] <= 1'b0;
			end
			if (cmd.expire) begin
				armed_q[best_idx_q] <= 1'b0;
			end
			vld_s1 <= cmd.scan_rd;
			if (cmd.scan_clr) begin
				best_v_q <= 1'b0;
				cnt_q    <= '0;
			end else if (hit) begin
				cnt_q <= cnt_q + 1'b1;
				if (better) begin
					best_v_q <= 1'b1;
				end
			end
			strobe_q <= cmd.arm || cmd.stop || cmd.expire;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			id_q      <= timer_id;
			timeout_q <= timeout;
		end
		// due = now + timeout, then remainder by granularity
		if (cmd.sum) begin
			sum_q <= sum_next;
			div_q <= sum_next;
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= rem2;
			div_q <= {div_q[TIME_W-3:0], 2'b00};
		end
		if (cmd.round) begin
			sum_q <= sum_q + TIME_W'(pad);
		end
		idx_s1 <= cmd.scan_addr;
		if (!cmd.scan_clr && hit && better) begin
			best_idx_q <= idx_s1;
			best_due_q <= rdata;
		end
		// Result register
		if (cmd.arm) begin
			res_id_q   <= id_q;
			res_kind_q <= KIND_STARTED;
			res_due_q  <= sum_q;
			res_last_q <= 1'b1;
		end else if (cmd.stop) begin
			res_id_q   <= id_q;
			res_kind_q <= armed_q[id_idx] ? KIND_STOPPED : KIND_NOT_ARMED;
			res_due_q  <= armed_q[id_idx] ? rdata : '0;
			res_last_q <= 1'b1;
		end else if (cmd.expire) begin
			res_id_q   <= ID_W'(best_idx_q);
			res_kind_q <= KIND_EXPIRED;
			res_due_q  <= best_due_q;
			res_last_q <= cmd.last;
		end
	end

	assign strobe       = strobe_q;
	assign timer_id_res = res_id_q;
	assign kind         = res_kind_q;
	assign due_time     = res_due_q;
	assign last         = res_last_q;

endmodule

// ===== rtl/core/timer_queue_manager.sv =====
// Timer table with a 64-bit tick time base. An item is taken when start is
// high and busy is low; each result appears for one cycle with strobe high
// and cannot be held off, so the receiver must take it then. A start stays
// busy while the remainder unit rounds the due time, two bits of the 64-bit
// sum per cycle. A tick scans the due-time memory one slot per cycle
// through its single read port: it first advances time, then makes one
// pass per expiry reported, and one pass when nothing is due. Results of a
// tick come in due-time order, ties by lower slot, last marks the final
// one. The granularity register may be written only while busy is low and
// no tick is pending.
module timer_queue_manager (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    func,
	input  logic [tqm_pkg::ID_W-1:0]      timer_id,
	input  logic [tqm_pkg::TIMEOUT_W-1:0] timeout,
	input  logic                          cfg_we,
	input  logic [tqm_pkg::GRAN_W-1:0]    cfg_wdata,
	output logic                          strobe,
	output logic [tqm_pkg::ID_W-1:0]      timer_id_res,
	output logic [1:0]                    kind,
	output logic [tqm_pkg::TIME_W-1:0]    due_time,
	output logic                          last
);

	import tqm_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Sequencer
	tqm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.func     (func),
		.timer_id (timer_id),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy)
	);

	// Time base, timer table and result register
	tqm_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.timer_id     (timer_id),
		.timeout      (timeout),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.strobe       (strobe),
		.timer_id_res (timer_id_res),
		.kind         (kind),
		.due_time     (due_time),
		.last         (last)
	);

	// A stop of an idle timer reports a zero due time
	a_not_armed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (kind == KIND_NOT_ARMED) |-> (due_time == '0))
		else $error("not-armed stop with nonzero due time");

	// Start and stop give a single transfer
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (kind != KIND_EXPIRED) |-> last)
		else $error("start or stop result without last");

	// More expiries follow a non-final one, so the scan is still running
	a_expiry_more: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (kind == KIND_EXPIRED) && !last |-> busy)
		else $error("expiry without last while idle");

	// Expiries never exceed the current time
	a_expiry_due: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (kind == KIND_EXPIRED) |-> (due_time <= u_dp.now_q))
		else $error("expired timer not yet due");

endmodule

// ===== test/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tqm_pkg::*;

	// Quiet cycles tolerated before the run is declared hung
	localparam int QUIET_LIMIT   = 2000;
	// Cycles allowed for a tick that reports nothing to finish its scan
	localparam int SETTLE_CYCLES = 40;
	// Granularity settings visited by the random phases
	localparam int GRAN_PLAN [7] = '{1, 3, 0, 1023, 7, 1000, 2};

	typedef struct {
		func_t                func;
		logic [ID_W-1:0]      id;
		logic [TIMEOUT_W-1:0] timeout;
	} timer_cmd_t;

	typedef struct {
		logic [ID_W-1:0]   id;
		kind_t             kind;
		logic [TIME_W-1:0] due;
		logic              last;
	} timer_report_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [1:0]           func = 2'b00;
	logic [ID_W-1:0]      timer_id = '0;
	logic [TIMEOUT_W-1:0] timeout = '0;
	logic                 cfg_we = 1'b0;
	logic [GRAN_W-1:0]    cfg_wdata = '0;
	logic                 strobe;
	logic [ID_W-1:0]      timer_id_res;
	logic [1:0]           kind;
	logic [TIME_W-1:0]    due_time;
	logic                 last;

	// Shadow copy of the timer table
	logic [TIME_W-1:0] model_now;
	logic [TIME_W-1:0] model_due [TIMERS];
	logic              model_armed [TIMERS];
	logic [GRAN_W-1:0] model_gran;

	timer_cmd_t    cmd_queue [$];
	timer_report_t expected_reports [$];

	int gap_mode = 1;
	int gap_left;
	int quiet_cycles = 0;
	int cmds_sent = 0;
	int reports_checked = 0;
	int mismatches = 0;
	int gran_writes = 0;

	timer_queue_manager uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.timer_id     (timer_id),
		.timeout      (timeout),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.strobe       (strobe),
		.timer_id_res (timer_id_res),
		.kind         (kind),
		.due_time     (due_time),
		.last         (last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Apply one command to the shadow table and queue the reports it causes
	task automatic timer_table_apply(input func_t f, input logic [ID_W-1:0] id,
			input logic [TIMEOUT_W-1:0] to);
		logic [TIME_W-1:0] g;
		logic [TIME_W-1:0] sum;
		logic [TIME_W-1:0] rem;
		timer_report_t     prev;
		logic              have_prev;
		int                best;
		int                n;
		if (f == FUNC_TICK) begin
			model_now = model_now + 1'b1;
			n = 0;
			have_prev = 1'b0;
			// pick earliest due slot, lowest id on ties, until none is due or MAX_RESULTS are taken
			do begin
				best = -1;
				for (int i = 0; i < TIMERS; i++)
					if (model_armed[i] && model_due[i] <= model_now &&
							(best < 0 || model_due[i] < model_due[best]))
						best = i;
				if (best >= 0) begin
					if (have_prev)
						expected_reports.push_back(prev);
					model_armed[best] = 1'b0;
					prev = '{id: ID_W'(best), kind: KIND_EXPIRED, due: model_due[best],
						last: 1'b0};
					have_prev = 1'b1;
					n++;
				end
			end while (best >= 0 && n < MAX_RESULTS);
			if (have_prev) begin
				prev.last = 1'b1;
				expected_reports.push_back(prev);
			end
		end else if (f == FUNC_START && int'(id) < TIMERS) begin
			// zero granularity means no rounding
			g = (model_gran == '0) ? TIME_W'(1) : TIME_W'(model_gran);
			sum = model_now + TIME_W'(to);
			rem = sum % g;
			if (rem != '0)
				sum = sum + (g - rem);
			model_due[id] = sum;
			model_armed[id] = 1'b1;
			expected_reports.push_back('{id: id, kind: KIND_STARTED, due: sum, last: 1'b1});
		end else if (f == FUNC_STOP && int'(id) < TIMERS) begin
			if (model_armed[id]) begin
				model_armed[id] = 1'b0;
				expected_reports.push_back('{id: id, kind: KIND_STOPPED, due: model_due[id],
					last: 1'b1});
			end else begin
				expected_reports.push_back('{id: id, kind: KIND_NOT_ARMED, due: '0,
					last: 1'b1});
			end
		end
	endtask

	// Mostly short gaps, a few long ones; none when gap_mode is 0
	function automatic int idle_gap();
		int r;
		if (gap_mode == 0)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Driver: one command per transfer, start held high across busy cycles
	always @(posedge clk or negedge arst_n) begin : driver
		timer_cmd_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
			func <= FUNC_TICK;
			timer_id <= '0;
			timeout <= '0;
			gap_left <= 0;
		end else begin
			if (start && !busy) begin
				timer_table_apply(func_t'(func), timer_id, timeout);
				cmds_sent++;
			end
			if (!start || !busy) begin
				if (gap_left > 0) begin
					start <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (cmd_queue.size() != 0) begin
					nxt = cmd_queue.pop_front();
					start <= 1'b1;
					func <= nxt.func;
					timer_id <= nxt.id;
					timeout <= nxt.timeout;
					gap_left <= idle_gap();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every strobed report against the oldest expectation
	always @(posedge clk) begin : monitor
		timer_report_t want;
		if (arst_n && strobe) begin
			if (expected_reports.size() == 0) begin
				$error("unexpected report: timer_id_res %0d kind %0d due_time %0d",
					timer_id_res, kind, due_time);
				mismatches++;
			end else begin
				want = expected_reports.pop_front();
				reports_checked++;
				if (timer_id_res !== want.id) begin
					$error("timer_id_res: expected %0d, actual %0d", want.id, timer_id_res);
					mismatches++;
				end
				if (kind !== want.kind) begin
					$error("kind: expected %0d, actual %0d", want.kind, kind);
					mismatches++;
				end
				if (due_time !== want.due) begin
					$error("due_time: expected %0d, actual %0d", want.due, due_time);
					mismatches++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, actual %0d", want.last, last);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: any transfer, report or register write counts as progress
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: nothing moved for %0d cycles, %0d reports outstanding",
				quiet_cycles, expected_reports.size());
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic add_cmd(input func_t f, input int id, input logic [TIMEOUT_W-1:0] to);
		cmd_queue.push_back('{func: f, id: ID_W'(id), timeout: to});
	endtask

	// Wait until everything sent is accepted and reported and the block is idle
	task automatic wait_drained();
		do
			@(negedge clk);
		while (cmd_queue.size() != 0 || start || busy || expected_reports.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
		while (busy)
			@(negedge clk);
	endtask

	task automatic set_granularity(input logic [GRAN_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		model_gran = value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		gran_writes++;
	endtask

	// Random phase: mostly arm-then-tick sequences, plus stops, long timeouts, noise
	task automatic fill_random_phase(input int count, input int gran);
		int g;
		int n;
		int k;
		int sel;
		logic burst_done;
		g = (gran == 0) ? 1 : gran;
		n = 0;
		burst_done = 1'b0;
		while (n < count) begin
			sel = $urandom_range(0, 99);
			if (sel < 40) begin
				k = $urandom_range(1, 4);
				repeat (k) add_cmd(FUNC_START, $urandom_range(0, TIMERS - 1),
					TIMEOUT_W'($urandom_range(0, 8)));
				n += k;
				k = $urandom_range(1, (g <= 8) ? 12 : 4);
				repeat (k) add_cmd(FUNC_TICK, $urandom_range(0, TIMERS - 1), $urandom());
				n += k;
			end else if (sel < 55) begin
				add_cmd(FUNC_STOP, $urandom_range(0, TIMERS - 1), $urandom());
				n++;
			end else if (sel < 65) begin
				add_cmd(FUNC_START, $urandom_range(0, TIMERS - 1), $urandom());
				n++;
			end else if (sel < 70) begin
				// ignored by the block, not counted
				add_cmd(FUNC_NONE, $urandom_range(0, TIMERS - 1), $urandom());
			end else if (sel < 75 && !burst_done && g <= 8) begin
				// arm every slot with the same due time, then tick until all fire
				for (int i = 0; i < TIMERS; i++)
					add_cmd(FUNC_START, i, '0);
				repeat (g) add_cmd(FUNC_TICK, 0, '0);
				n += TIMERS + g;
				burst_done = 1'b1;
			end else begin
				k = $urandom_range(1, 5);
				repeat (k) add_cmd(FUNC_TICK, $urandom_range(0, TIMERS - 1), $urandom());
				n += k;
			end
		end
	endtask

	initial begin : stimulus
		model_now = '0;
		model_gran = GRAN_RESET;
		for (int i = 0; i < TIMERS; i++) begin
			model_due[i] = '0;
			model_armed[i] = 1'b0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed at reset granularity: stop of idle slot, extremes, re-arm
		add_cmd(FUNC_STOP, 0, '0);
		add_cmd(FUNC_START, 0, '0);
		add_cmd(FUNC_START, TIMERS - 1, '1);
		add_cmd(FUNC_START, 5, 32'd1);
		add_cmd(FUNC_START, 5, 32'd150);
		add_cmd(FUNC_STOP, TIMERS - 1, '0);
		add_cmd(FUNC_NONE, TIMERS - 1, '1);
		add_cmd(FUNC_TICK, 0, '0);
		add_cmd(FUNC_TICK, TIMERS - 1, '1);
		add_cmd(FUNC_STOP, 5, '0);
		add_cmd(FUNC_STOP, 5, '0);
		wait_drained();

		// Directed ordering: earlier due first, equal due by lower slot
		set_granularity(10'd1);
		add_cmd(FUNC_START, 7, 32'd2);
		add_cmd(FUNC_START, 3, 32'd2);
		add_cmd(FUNC_START, 9, 32'd1);
		add_cmd(FUNC_START, 20, 32'd0);
		add_cmd(FUNC_TICK, 0, '0);
		add_cmd(FUNC_TICK, 0, '0);
		add_cmd(FUNC_TICK, 0, '0);
		wait_drained();

		// Random phases, each at its own granularity
		for (int p = 0; p < 7; p++) begin
			set_granularity(GRAN_W'(GRAN_PLAN[p]));
			gap_mode = (p % 3 == 1) ? 0 : 1;
			fill_random_phase(20, GRAN_PLAN[p]);
			wait_drained();
		end

		$display("covered %0d commands, %0d reports checked, %0d granularity writes",
			cmds_sent, reports_checked, gran_writes);
		if (mismatches == 0 && expected_reports.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
